>>> rtl/b64u_pkg.sv
// Shared types, constants and the character mapping for the base64url encoder.
package b64u_pkg;

  localparam int unsigned GroupW = 24;
  localparam logic [7:0] PadChar = 8'h3d;
  localparam logic [5:0] SliceMask = 6'h3f;

  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        held;
    logic              last;
  } b64u_group_t;

  function automatic logic [7:0] b64u_char(input logic [5:0] sextet);
    logic [7:0] v;
    logic [7:0] c;
    v = {2'b00, sextet & SliceMask};
    priority if (v < 8'd26) begin
      c = v + 8'h41;
    end else if (v < 8'd52) begin
      c = v + 8'd71;
    end else if (v < 8'd62) begin
      c = v - 8'd4;
    end else if (v == 8'd62) begin
      c = 8'h2d;
    end else begin
      c = 8'h5f;
    end
    return c;
  endfunction

endpackage

>>> rtl/base64url_stream_encoder_core.sv
// A group's first character is loaded when the group heads the queue and the back end is free.
// Throughput: one byte per cycle is taken while the two-group queue has room;
// the back end sends one character per cycle, four per group, while groups are queued and out_ready_i is high.
// Reset clears the held bytes, the byte count, the queue and the output valid flag.
// Top level of the base64url stream encoder.
module base64url_stream_encoder_core import b64u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  b64u_group_t push_data;
  b64u_group_t pop_data;

  b64u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .is_last_i   (is_last_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  b64u_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .full_o      (full)
  );

  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .group_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

>>> rtl/b64u_front.sv
// Front end: accepts bytes, gathers them into groups and pushes finished groups.
module b64u_front import b64u_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        is_last_i,
  input  logic        full_i,
  output logic        push_o,
  output b64u_group_t push_data_o
);

  logic [15:0] pending_q, pending_d;
  logic [1:0]  count_q, count_d;
  logic [1:0]  held;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign held       = count_q + 2'd1;

  always_comb begin
    pending_d   = pending_q;
    count_d     = count_q;
    push_o      = 1'b0;
    push_data_o.held  = held;
    push_data_o.last  = is_last_i;
    unique case (held)
      2'd1:    push_data_o.group = {in_byte_i, 16'h0000};
      2'd2:    push_data_o.group = {pending_q[7:0], in_byte_i, 8'h00};
      default: push_data_o.group = {pending_q, in_byte_i};
    endcase
    if (accept) begin
      if (held != 2'd3 && !is_last_i) begin
        pending_d = {pending_q[7:0], in_byte_i};
        count_d   = held;
      end else begin
        push_o    = 1'b1;
        pending_d = 16'h0000;
        count_d   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 16'h0000;
      count_q   <= 2'd0;
    end else begin
      pending_q <= pending_d;
      count_q   <= count_d;
    end
  end

endmodule

>>> rtl/b64u_fifo.sv
// Two-entry queue of finished groups between the front and back ends.
module b64u_fifo import b64u_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  b64u_group_t push_data_i,
  input  logic        pop_i,
  output b64u_group_t pop_data_o,
  output logic        empty_o,
  output logic        full_o
);

  b64u_group_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign empty_o    = (count_q == 2'd0);
  assign full_o     = (count_q == 2'd2);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> rtl/b64u_back.sv
// Back end: turns each queued group into four characters through an output register.
module b64u_back import b64u_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  b64u_group_t group_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        out_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;
  logic [5:0] sextet;
  logic       is_pad;
  logic [7:0] char_d;

  assign load = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && (idx_q == 2'd3);

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = group_i.group[23:18];
      2'd1:    sextet = group_i.group[17:12];
      2'd2:    sextet = group_i.group[11:6];
      default: sextet = group_i.group[5:0];
    endcase
    is_pad = ((idx_q == 2'd2) && (group_i.held < 2'd2)) ||
             ((idx_q == 2'd3) && (group_i.held < 2'd3));
    char_d = is_pad ? PadChar : b64u_char(sextet);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= group_i.last && (idx_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule
